@@ hw/rtl/spkmix_pkg.sv @@
`default_nettype none

package spkmix_pkg;

	localparam int NCH = 6;
	localparam int SAMPLE_W = 24;
	localparam int SUM_W = SAMPLE_W + 3;
	localparam int CNT_W = 3;
	localparam int WGT_FRAC = 16;
	localparam int WGT_W = WGT_FRAC + 1;
	localparam int PROD_W = SAMPLE_W + WGT_W;
	localparam int MAX_CHANNELS_DEF = 6;

	localparam logic [WGT_FRAC-1:0] W_SQRT_HALF = 16'd46341;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_CH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_CH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCUM = 3'd3;

	localparam logic [CNT_W-1:0] SRC_CH_RST = 3'd2;
	localparam logic [CNT_W-1:0] DST_CH_RST = 3'd2;
	localparam logic INTERP_RST = 1'b0;
	localparam logic ACCUM_RST = 1'b1;

	localparam logic [CNT_W-1:0] CH_MONO = 3'd1;
	localparam logic [CNT_W-1:0] CH_STEREO = 3'd2;
	localparam logic [CNT_W-1:0] CH_QUAD = 3'd4;
	localparam logic [CNT_W-1:0] CH_51 = 3'd6;

	typedef logic [3:0] rule_t;
	localparam rule_t RULE_DISCRETE = 4'd0;
	localparam rule_t RULE_MONO_TO_PAIR = 4'd1;
	localparam rule_t RULE_MONO_TO_51 = 4'd2;
	localparam rule_t RULE_STEREO_UP = 4'd3;
	localparam rule_t RULE_QUAD_TO_51 = 4'd4;
	localparam rule_t RULE_STEREO_TO_MONO = 4'd5;
	localparam rule_t RULE_QUAD_TO_MONO = 4'd6;
	localparam rule_t RULE_51_TO_MONO = 4'd7;
	localparam rule_t RULE_QUAD_TO_STEREO = 4'd8;
	localparam rule_t RULE_51_TO_STEREO = 4'd9;
	localparam rule_t RULE_51_TO_QUAD = 4'd10;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef sample_t [NCH-1:0] frame_t;

	typedef struct packed {
		rule_t rule;
		logic [NCH-1:0] dmask;
	} ctl_t;

	typedef struct packed {
		sample_t src_ch0;
		sample_t src_ch1;
		sample_t src_ch2;
		sample_t src_ch3;
		sample_t src_ch4;
		sample_t src_ch5;
		sample_t dst_ch0;
		sample_t dst_ch1;
		sample_t dst_ch2;
		sample_t dst_ch3;
		sample_t dst_ch4;
		sample_t dst_ch5;
	} in_t;

	typedef struct packed {
		sample_t out_ch0;
		sample_t out_ch1;
		sample_t out_ch2;
		sample_t out_ch3;
		sample_t out_ch4;
		sample_t out_ch5;
	} out_t;

endpackage

`default_nettype wire

@@ hw/rtl/spkmix_decode.sv @@
`default_nettype none

module spkmix_decode #(
	parameter int MAX_CHANNELS = spkmix_pkg::MAX_CHANNELS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             en,
	input  wire                             in_valid,
	input  spkmix_pkg::in_t                 in_data,
	input  wire [spkmix_pkg::CNT_W-1:0]     src_cnt,
	input  wire [spkmix_pkg::CNT_W-1:0]     dst_cnt,
	input  wire                             interp,
	input  wire                             accum,
	output logic                            vld_s1,
	output spkmix_pkg::ctl_t                ctl_s1,
	output spkmix_pkg::frame_t              src_s1,
	output spkmix_pkg::frame_t              dst_s1
);

	logic [spkmix_pkg::CNT_W-1:0] ns;
	logic [spkmix_pkg::CNT_W-1:0] nd;
	logic [spkmix_pkg::CNT_W-1:0] nmin;
	spkmix_pkg::frame_t src_raw;
	spkmix_pkg::frame_t dst_raw;
	spkmix_pkg::frame_t src_m;
	spkmix_pkg::frame_t dst_m;
	spkmix_pkg::ctl_t ctl;

	function automatic logic [spkmix_pkg::CNT_W-1:0] clamp_cnt(
		input logic [spkmix_pkg::CNT_W-1:0] c
	);
		logic [spkmix_pkg::CNT_W-1:0] r;
		r = c;
		if (c == '0) begin
			r = spkmix_pkg::CNT_W'(1);
		end else if (c > spkmix_pkg::CNT_W'(MAX_CHANNELS)) begin
			r = spkmix_pkg::CNT_W'(MAX_CHANNELS);
		end
		return r;
	endfunction

	assign ns = clamp_cnt(src_cnt);
	assign nd = clamp_cnt(dst_cnt);
	assign nmin = (ns < nd) ? ns : nd;

	assign src_raw[0] = in_data.src_ch0;
	assign src_raw[1] = in_data.src_ch1;
	assign src_raw[2] = in_data.src_ch2;
	assign src_raw[3] = in_data.src_ch3;
	assign src_raw[4] = in_data.src_ch4;
	assign src_raw[5] = in_data.src_ch5;
	assign dst_raw[0] = in_data.dst_ch0;
	assign dst_raw[1] = in_data.dst_ch1;
	assign dst_raw[2] = in_data.dst_ch2;
	assign dst_raw[3] = in_data.dst_ch3;
	assign dst_raw[4] = in_data.dst_ch4;
	assign dst_raw[5] = in_data.dst_ch5;

	always_comb begin
		for (int i = 0; i < spkmix_pkg::NCH; i++) begin
			src_m[i] = (spkmix_pkg::CNT_W'(i) < ns) ? src_raw[i] : '0;
			dst_m[i] = (spkmix_pkg::CNT_W'(i) < nd && accum) ? dst_raw[i] : '0;
			ctl.dmask[i] = spkmix_pkg::CNT_W'(i) < nmin;
		end
		ctl.rule = spkmix_pkg::RULE_DISCRETE;
		if (ns == nd || interp) begin
			ctl.rule = spkmix_pkg::RULE_DISCRETE;
		end else if (ns == spkmix_pkg::CH_MONO
				&& (nd == spkmix_pkg::CH_STEREO || nd == spkmix_pkg::CH_QUAD)) begin
			ctl.rule = spkmix_pkg::RULE_MONO_TO_PAIR;
		end else if (ns == spkmix_pkg::CH_MONO && nd == spkmix_pkg::CH_51) begin
			ctl.rule = spkmix_pkg::RULE_MONO_TO_51;
		end else if (ns == spkmix_pkg::CH_STEREO
				&& (nd == spkmix_pkg::CH_QUAD || nd == spkmix_pkg::CH_51)) begin
			ctl.rule = spkmix_pkg::RULE_STEREO_UP;
		end else if (ns == spkmix_pkg::CH_QUAD && nd == spkmix_pkg::CH_51) begin
			ctl.rule = spkmix_pkg::RULE_QUAD_TO_51;
		end else if (ns == spkmix_pkg::CH_STEREO && nd == spkmix_pkg::CH_MONO) begin
			ctl.rule = spkmix_pkg::RULE_STEREO_TO_MONO;
		end else if (ns == spkmix_pkg::CH_QUAD && nd == spkmix_pkg::CH_MONO) begin
			ctl.rule = spkmix_pkg::RULE_QUAD_TO_MONO;
		end else if (ns == spkmix_pkg::CH_51 && nd == spkmix_pkg::CH_MONO) begin
			ctl.rule = spkmix_pkg::RULE_51_TO_MONO;
		end else if (ns == spkmix_pkg::CH_QUAD && nd == spkmix_pkg::CH_STEREO) begin
			ctl.rule = spkmix_pkg::RULE_QUAD_TO_STEREO;
		end else if (ns == spkmix_pkg::CH_51 && nd == spkmix_pkg::CH_STEREO) begin
			ctl.rule = spkmix_pkg::RULE_51_TO_STEREO;
		end else if (ns == spkmix_pkg::CH_51 && nd == spkmix_pkg::CH_QUAD) begin
			ctl.rule = spkmix_pkg::RULE_51_TO_QUAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl;
			src_s1 <= src_m;
			dst_s1 <= dst_m;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/spkmix_weight.sv @@
`default_nettype none

module spkmix_weight (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  wire                   vld_s1,
	input  spkmix_pkg::ctl_t      ctl_s1,
	input  spkmix_pkg::frame_t    src_s1,
	input  spkmix_pkg::frame_t    dst_s1,
	output logic                  vld_s2,
	output spkmix_pkg::ctl_t      ctl_s2,
	output spkmix_pkg::frame_t    src_s2,
	output spkmix_pkg::frame_t    dst_s2,
	output spkmix_pkg::frame_t    rt_s2
);

	localparam logic signed [spkmix_pkg::WGT_W-1:0] K_RT = {1'b0, spkmix_pkg::W_SQRT_HALF};

	spkmix_pkg::frame_t rt;

	// The product is floored to Q1.23 by dropping the weight's fraction bits.
	for (genvar i = 0; i < spkmix_pkg::NCH; i++) begin : g_mul
		logic signed [spkmix_pkg::PROD_W-1:0] prod;
		assign prod = src_s1[i] * K_RT;
		assign rt[i] = prod[spkmix_pkg::SAMPLE_W+spkmix_pkg::WGT_FRAC-1:spkmix_pkg::WGT_FRAC];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2 <= ctl_s1;
			src_s2 <= src_s1;
			dst_s2 <= dst_s1;
			rt_s2 <= rt;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/spkmix_sum.sv @@
`default_nettype none

module spkmix_sum (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  wire                   vld_s2,
	input  spkmix_pkg::ctl_t      ctl_s2,
	input  spkmix_pkg::frame_t    src_s2,
	input  spkmix_pkg::frame_t    dst_s2,
	input  spkmix_pkg::frame_t    rt_s2,
	output logic                  out_valid,
	output spkmix_pkg::out_t      out_data
);

	typedef logic signed [spkmix_pkg::SUM_W-1:0] acc_t;

	acc_t s [spkmix_pkg::NCH];
	acc_t h [spkmix_pkg::NCH];
	acc_t q [spkmix_pkg::NCH];
	acc_t r [spkmix_pkg::NCH];
	acc_t acc [spkmix_pkg::NCH];
	acc_t acc_s3 [spkmix_pkg::NCH];
	logic vld_s3;
	spkmix_pkg::frame_t sat;

	function automatic spkmix_pkg::sample_t sat_sample(input acc_t v);
		spkmix_pkg::sample_t res;
		if (&v[spkmix_pkg::SUM_W-1:spkmix_pkg::SAMPLE_W-1]
				|| ~|v[spkmix_pkg::SUM_W-1:spkmix_pkg::SAMPLE_W-1]) begin
			res = v[spkmix_pkg::SAMPLE_W-1:0];
		end else if (v[spkmix_pkg::SUM_W-1]) begin
			res = {1'b1, {(spkmix_pkg::SAMPLE_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(spkmix_pkg::SAMPLE_W-1){1'b1}}};
		end
		return res;
	endfunction

	always_comb begin
		for (int i = 0; i < spkmix_pkg::NCH; i++) begin
			s[i] = acc_t'(src_s2[i]);
			h[i] = acc_t'(src_s2[i] >>> 1);
			q[i] = acc_t'(src_s2[i] >>> 2);
			r[i] = acc_t'(rt_s2[i]);
		end
	end

	always_comb begin
		for (int i = 0; i < spkmix_pkg::NCH; i++) begin
			acc[i] = acc_t'(dst_s2[i]);
		end
		unique case (ctl_s2.rule)
			spkmix_pkg::RULE_DISCRETE: begin
				for (int i = 0; i < spkmix_pkg::NCH; i++) begin
					if (ctl_s2.dmask[i]) begin
						acc[i] = acc[i] + s[i];
					end
				end
			end
			spkmix_pkg::RULE_MONO_TO_PAIR: begin
				acc[0] = acc[0] + s[0];
				acc[1] = acc[1] + s[0];
			end
			spkmix_pkg::RULE_MONO_TO_51: begin
				acc[2] = acc[2] + s[0];
			end
			spkmix_pkg::RULE_STEREO_UP: begin
				acc[0] = acc[0] + s[0];
				acc[1] = acc[1] + s[1];
			end
			spkmix_pkg::RULE_QUAD_TO_51: begin
				acc[0] = acc[0] + s[0];
				acc[1] = acc[1] + s[1];
				acc[4] = acc[4] + s[2];
				acc[5] = acc[5] + s[3];
			end
			spkmix_pkg::RULE_STEREO_TO_MONO: begin
				acc[0] = acc[0] + h[0] + h[1];
			end
			spkmix_pkg::RULE_QUAD_TO_MONO: begin
				acc[0] = acc[0] + q[0] + q[1] + q[2] + q[3];
			end
			spkmix_pkg::RULE_51_TO_MONO: begin
				acc[0] = acc[0] + r[0] + r[1] + s[2] + h[4] + h[5];
			end
			spkmix_pkg::RULE_QUAD_TO_STEREO: begin
				acc[0] = acc[0] + h[0] + h[2];
				acc[1] = acc[1] + h[1] + h[3];
			end
			spkmix_pkg::RULE_51_TO_STEREO: begin
				acc[0] = acc[0] + s[0] + r[2] + r[4];
				acc[1] = acc[1] + s[1] + r[2] + r[5];
			end
			spkmix_pkg::RULE_51_TO_QUAD: begin
				acc[0] = acc[0] + s[0] + r[2];
				acc[1] = acc[1] + s[1] + r[2];
				acc[2] = acc[2] + s[4];
				acc[3] = acc[3] + s[5];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < spkmix_pkg::NCH; i++) begin
			sat[i] = sat_sample(acc_s3[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
			out_valid <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < spkmix_pkg::NCH; i++) begin
				acc_s3[i] <= acc[i];
			end
			out_data.out_ch0 <= sat[0];
			out_data.out_ch1 <= sat[1];
			out_data.out_ch2 <= sat[2];
			out_data.out_ch3 <= sat[3];
			out_data.out_ch4 <= sat[4];
			out_data.out_ch5 <= sat[5];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/speaker_channel_mixer_core.sv @@
`default_nettype none

// Mixes one audio frame of up to six Q1.23 source samples into six destination samples per
// request, taking a new frame in every cycle in which the input is not stalled. A frame passes
// through four register stages (channel decode and masking, square-root-of-one-half
// multipliers, summation, saturation), in that order. A stalled valid result holds the
// whole pipeline, and the input is stalled in exactly those cycles. Configuration writes
// are always ready and take effect on the next accepted frame; they should be made only
// while no frame is in flight.

module speaker_channel_mixer_core #(
	parameter int MAX_CHANNELS = spkmix_pkg::MAX_CHANNELS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  spkmix_pkg::in_t                    in_data,
	output logic                               out_valid,
	input  wire                                out_stall,
	output spkmix_pkg::out_t                   out_data,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [spkmix_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [spkmix_pkg::CNT_W-1:0]        cfg_data
);

	logic en;
	logic [spkmix_pkg::CNT_W-1:0] src_cnt_q;
	logic [spkmix_pkg::CNT_W-1:0] dst_cnt_q;
	logic interp_q;
	logic accum_q;

	logic vld_s1;
	logic vld_s2;
	spkmix_pkg::ctl_t ctl_s1;
	spkmix_pkg::ctl_t ctl_s2;
	spkmix_pkg::frame_t src_s1;
	spkmix_pkg::frame_t dst_s1;
	spkmix_pkg::frame_t src_s2;
	spkmix_pkg::frame_t dst_s2;
	spkmix_pkg::frame_t rt_s2;

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cnt_q <= spkmix_pkg::SRC_CH_RST;
			dst_cnt_q <= spkmix_pkg::DST_CH_RST;
			interp_q <= spkmix_pkg::INTERP_RST;
			accum_q <= spkmix_pkg::ACCUM_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				spkmix_pkg::CFG_SRC_CH: src_cnt_q <= cfg_data;
				spkmix_pkg::CFG_DST_CH: dst_cnt_q <= cfg_data;
				spkmix_pkg::CFG_INTERP: interp_q <= cfg_data[0];
				spkmix_pkg::CFG_ACCUM: accum_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	spkmix_decode #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.in_data(in_data),
		.src_cnt(src_cnt_q),
		.dst_cnt(dst_cnt_q),
		.interp(interp_q),
		.accum(accum_q),
		.vld_s1(vld_s1),
		.ctl_s1(ctl_s1),
		.src_s1(src_s1),
		.dst_s1(dst_s1)
	);

	spkmix_weight u_weight (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_s1(vld_s1),
		.ctl_s1(ctl_s1),
		.src_s1(src_s1),
		.dst_s1(dst_s1),
		.vld_s2(vld_s2),
		.ctl_s2(ctl_s2),
		.src_s2(src_s2),
		.dst_s2(dst_s2),
		.rt_s2(rt_s2)
	);

	spkmix_sum u_sum (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_s2(vld_s2),
		.ctl_s2(ctl_s2),
		.src_s2(src_s2),
		.dst_s2(dst_s2),
		.rt_s2(rt_s2),
		.out_valid(out_valid),
		.out_data(out_data)
	);

endmodule

`default_nettype wire

@@ hw/rtl/spkmix_checker.sv @@
`default_nettype none

module spkmix_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                in_valid,
	input wire                                in_stall,
	input wire                                out_valid,
	input wire                                out_stall,
	input spkmix_pkg::out_t                   out_data,
	input wire                                cfg_ready
);

	// A stalled result stays and holds its samples.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// The input is held back only by a stalled result.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// An accepted request passes the decode, weight and summation stages to the output while the output is not stalled.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("accepted request did not reach the output");

	// Configuration writes are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind speaker_channel_mixer_core spkmix_checker u_spkmix_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data),
	.cfg_ready(cfg_ready)
);

`default_nettype wire
